/* design/pfrt_pkg.sv */
// Package for the packet filter rule table.
// Holds the opcode, status and state codes, the item and rule types, and the rule builder.
// No dependencies.
package pfrt_pkg;

	typedef enum logic [1:0] {
		OP_CLASSIFY = 2'd0,
		OP_ADD      = 2'd1,
		OP_MODIFY   = 2'd2,
		OP_DELETE   = 2'd3
	} op_e;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EXISTS   = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_CHECK,
		B_SH_READ,
		B_SH_WRITE,
		B_RESULT
	} bst_e;

	typedef struct packed {
		op_e         op;
		logic [63:0] key;
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [15:0] sport_lo;
		logic [15:0] sport_hi;
		logic [15:0] dport_lo;
		logic [15:0] dport_hi;
		logic [7:0]  proto;
		logic        rule_verdict;
		logic        range_bad;
	} item_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [15:0] sport_lo;
		logic [15:0] sport_hi;
		logic [15:0] dport_lo;
		logic [15:0] dport_hi;
		logic [7:0]  proto;
		logic        verdict;
	} rule_t;

	function automatic rule_t make_rule(item_t it);
		rule_t r;
		r.key      = it.key;
		r.src_addr = it.src_addr;
		r.src_mask = it.src_mask;
		r.dst_addr = it.dst_addr;
		r.dst_mask = it.dst_mask;
		r.sport_lo = it.sport_lo;
		r.sport_hi = it.sport_hi;
		r.dport_lo = it.dport_lo;
		r.dport_hi = it.dport_hi;
		r.proto    = it.proto;
		r.verdict  = it.rule_verdict;
		return r;
	endfunction

endpackage

/* design/pfrt_front.sv */
// Front stage of the packet filter rule table: takes input transfers and decodes them.
// Checks port ranges and clears packet ports for protocols other than TCP and UDP.
// Depends on pfrt_pkg.
module pfrt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [271:0]         s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 q_valid,
	input  logic                 q_ready,
	output pfrt_pkg::item_t      q_item
);

	logic            valid_s1;
	pfrt_pkg::item_t item_s1;
	pfrt_pkg::item_t item_d;
	logic            port_use;

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_item   = item_s1;

	always_comb begin
		item_d.op           = pfrt_pkg::op_e'(s_tuser);
		item_d.key          = s_tdata[63:0];
		item_d.src_addr     = s_tdata[95:64];
		item_d.src_mask     = s_tdata[127:96];
		item_d.dst_addr     = s_tdata[159:128];
		item_d.dst_mask     = s_tdata[191:160];
		item_d.sport_lo     = s_tdata[207:192];
		item_d.sport_hi     = s_tdata[223:208];
		item_d.dport_lo     = s_tdata[239:224];
		item_d.dport_hi     = s_tdata[255:240];
		item_d.proto        = s_tdata[263:256];
		item_d.rule_verdict = s_tdata[264];
		item_d.range_bad    = (item_d.sport_lo > item_d.sport_hi) ||
			(item_d.dport_lo > item_d.dport_hi);
		port_use = (item_d.proto == pfrt_pkg::PROTO_TCP) ||
			(item_d.proto == pfrt_pkg::PROTO_UDP);
		if (item_d.op == pfrt_pkg::OP_CLASSIFY && !port_use) begin
			item_d.sport_lo = 16'd0;
			item_d.dport_lo = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* design/pfrt_queue.sv */
// Two-entry queue between the front and back parts of the packet filter rule table.
// Depends on pfrt_pkg.
module pfrt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  pfrt_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop,
	output pfrt_pkg::item_t pop_item
);

	pfrt_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/pfrt_back.sv */
// Back part of the packet filter rule table: rule memory, scan and shift sequencer, result register.
// Depends on pfrt_pkg.
module pfrt_back #(
	parameter int MAX_RULES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_pop,
	input  pfrt_pkg::item_t item,
	input  logic            default_verdict,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata
);

	localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW = $clog2(MAX_RULES + 1);

	pfrt_pkg::rule_t mem [MAX_RULES];
	pfrt_pkg::rule_t rdata_q;
	pfrt_pkg::rule_t wdata;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	logic            we;

	pfrt_pkg::bst_e  state_q, state_d;
	pfrt_pkg::item_t cur_q, cur_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [2:0]      status_q, status_d;
	logic            verdict_q, verdict_d;
	logic            hit_q, hit_d;
	logic            m_valid_q, m_valid_d;
	logic [7:0]      m_data_q, m_data_d;
	logic            match;
	logic            src_ok;
	logic            dst_ok;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		src_ok = (rdata_q.src_addr == 32'd0) ||
			((cur_q.src_addr & rdata_q.src_mask) == (rdata_q.src_addr & rdata_q.src_mask));
		dst_ok = (rdata_q.dst_addr == 32'd0) ||
			((cur_q.dst_addr & rdata_q.dst_mask) == (rdata_q.dst_addr & rdata_q.dst_mask));
		match = ((rdata_q.proto == 8'd0) || (rdata_q.proto == cur_q.proto)) && src_ok && dst_ok &&
			(rdata_q.sport_lo <= cur_q.sport_lo) && (cur_q.sport_lo <= rdata_q.sport_hi) &&
			(rdata_q.dport_lo <= cur_q.dport_lo) && (cur_q.dport_lo <= rdata_q.dport_hi);
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		status_d  = status_q;
		verdict_d = verdict_q;
		hit_d     = hit_q;
		m_valid_d = m_valid_q;
		m_data_d  = m_data_q;
		item_pop  = 1'b0;
		raddr     = idx_q[AW-1:0];
		waddr     = idx_q[AW-1:0];
		wdata     = rdata_q;
		we        = 1'b0;

		if (m_valid_q && m_tready) begin
			m_valid_d = 1'b0;
		end

		case (state_q)
			pfrt_pkg::B_IDLE: begin
				if (item_valid) begin
					item_pop  = 1'b1;
					cur_d     = item;
					idx_d     = '0;
					status_d  = pfrt_pkg::ST_OK;
					verdict_d = 1'b0;
					hit_d     = 1'b0;
					state_d   = pfrt_pkg::B_READ;
				end
			end
			pfrt_pkg::B_READ: begin
				if (idx_q == cnt_q) begin
					state_d = pfrt_pkg::B_RESULT;
					case (cur_q.op)
						pfrt_pkg::OP_CLASSIFY: begin
							verdict_d = default_verdict;
						end
						pfrt_pkg::OP_ADD: begin
							if (cur_q.range_bad) begin
								status_d = pfrt_pkg::ST_RANGE;
							end else if (cnt_q == CW'(MAX_RULES)) begin
								status_d = pfrt_pkg::ST_FULL;
							end else begin
								state_d = pfrt_pkg::B_SH_READ;
							end
						end
						default: begin
							status_d = pfrt_pkg::ST_NOTFOUND;
						end
					endcase
				end else begin
					state_d = pfrt_pkg::B_CHECK;
				end
			end
			pfrt_pkg::B_CHECK: begin
				if (cur_q.op == pfrt_pkg::OP_CLASSIFY) begin
					if (match) begin
						verdict_d = rdata_q.verdict;
						hit_d     = 1'b1;
						state_d   = pfrt_pkg::B_RESULT;
					end else begin
						idx_d   = idx_q + CW'(1);
						state_d = pfrt_pkg::B_READ;
					end
				end else if (rdata_q.key == cur_q.key) begin
					state_d = pfrt_pkg::B_RESULT;
					case (cur_q.op)
						pfrt_pkg::OP_ADD: begin
							status_d = pfrt_pkg::ST_EXISTS;
						end
						pfrt_pkg::OP_MODIFY: begin
							if (cur_q.range_bad) begin
								status_d = pfrt_pkg::ST_RANGE;
							end else begin
								we    = 1'b1;
								wdata = pfrt_pkg::make_rule(cur_q);
							end
						end
						default: begin
							state_d = pfrt_pkg::B_SH_READ;
						end
					endcase
				end else begin
					idx_d   = idx_q + CW'(1);
					state_d = pfrt_pkg::B_READ;
				end
			end
			pfrt_pkg::B_SH_READ: begin
				if (cur_q.op == pfrt_pkg::OP_ADD) begin
					if (idx_q == '0) begin
						we      = 1'b1;
						wdata   = pfrt_pkg::make_rule(cur_q);
						cnt_d   = cnt_q + CW'(1);
						state_d = pfrt_pkg::B_RESULT;
					end else begin
						raddr   = AW'(idx_q - CW'(1));
						state_d = pfrt_pkg::B_SH_WRITE;
					end
				end else begin
					if (idx_q + CW'(1) == cnt_q) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = pfrt_pkg::B_RESULT;
					end else begin
						raddr   = AW'(idx_q + CW'(1));
						state_d = pfrt_pkg::B_SH_WRITE;
					end
				end
			end
			pfrt_pkg::B_SH_WRITE: begin
				we      = 1'b1;
				state_d = pfrt_pkg::B_SH_READ;
				if (cur_q.op == pfrt_pkg::OP_ADD) begin
					idx_d = idx_q - CW'(1);
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			pfrt_pkg::B_RESULT: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d = 1'b1;
					m_data_d  = {3'd0, hit_q, verdict_q, status_q};
					state_d   = pfrt_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = pfrt_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pfrt_pkg::B_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		idx_q     <= idx_d;
		status_q  <= status_d;
		verdict_q <= verdict_d;
		hit_q     <= hit_d;
		m_data_q  <= m_data_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

/* design/packet_filter_rule_table_top.sv */
// Top level of the packet filter rule table.
// Connects pfrt_front, pfrt_queue and pfrt_back and holds the default verdict register.
// Depends on pfrt_pkg.

// Rules are held in priority order in a single-port-read memory, and the back sequencer visits
// them in order, first reading each rule and then checking it. An item passes through the front
// register and the queue before the back part takes it. With n valid rules, the back part does
// the following from taking an item until it loads the result:
// - A classify or modify that hits the rule at position k stops there.
// - An add that finds its key at position k also stops there.
// - Any of these that finds nothing, and an add refused for its range or a full table, scan
//   all n rules.
// - A successful add scans all n rules and then moves every rule down by one.
// - A successful delete scans to its rule and then moves every later rule up by one.
// The back part takes the next item only after the result register accepts this one. The front
// stage and a two-entry queue keep taking transfers while the back part works and while a
// result waits on m_tready, until both are full.
module packet_filter_rule_table_top #(
	parameter int MAX_RULES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rule_key, src_addr, src_mask, dst_addr, dst_mask, sport_lo, sport_hi, dport_lo,
	// dport_hi, proto, rule_verdict, then zero fill.
	input  logic [271:0] s_tdata,
	// opcode.
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, verdict, rule_hit, then zero fill.
	output logic [7:0]   m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	logic            default_verdict_q;
	logic            q_push;
	logic            q_push_ready;
	pfrt_pkg::item_t q_push_item;
	logic            q_pop_valid;
	logic            q_pop;
	pfrt_pkg::item_t q_pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_verdict_q <= 1'b1;
		end else if (cfg_we) begin
			default_verdict_q <= cfg_wdata;
		end
	end

	pfrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_push),
		.q_ready  (q_push_ready),
		.q_item   (q_push_item)
	);

	pfrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_push_ready),
		.push_item  (q_push_item),
		.pop_valid  (q_pop_valid),
		.pop        (q_pop),
		.pop_item   (q_pop_item)
	);

	pfrt_back #(
		.MAX_RULES (MAX_RULES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (q_pop_valid),
		.item_pop        (q_pop),
		.item            (q_pop_item),
		.default_verdict (default_verdict_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

endmodule

/* design/pfrt_checker.sv */
// Port checker for the packet filter rule table, bound to the top level.
// Depends on pfrt_pkg.
module pfrt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] == pfrt_pkg::ST_OK || m_tdata[2:0] == pfrt_pkg::ST_EXISTS ||
			m_tdata[2:0] == pfrt_pkg::ST_RANGE || m_tdata[2:0] == pfrt_pkg::ST_NOTFOUND ||
			m_tdata[2:0] == pfrt_pkg::ST_FULL)
		else $error("status out of range");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != pfrt_pkg::ST_OK |-> m_tdata[4:3] == 2'b00)
		else $error("error result carries a verdict");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:5] == 3'd0)
		else $error("result fill bits not zero");

endmodule

bind packet_filter_rule_table_top pfrt_checker u_pfrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/tb_packet_filter_rule_table_top.sv */
// Testbench for packet_filter_rule_table_top: drives classify, add, modify and delete
// transfers and checks every result against a behavioral model of the rule table.
// Depends on pfrt_pkg and the design files.
`timescale 1ns / 1ps

module tb_packet_filter_rule_table_top;

	typedef struct {
		pfrt_pkg::op_e   op;
		pfrt_pkg::rule_t r;
	} req_t;

	typedef struct {
		logic [2:0] status;
		logic       verdict;
		logic       hit;
	} answer_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [271:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [7:0]   m_tdata;
	logic         cfg_we = 0;
	logic         cfg_wdata = 0;

	req_t    pending[$];
	answer_t answers_due[$];
	pfrt_pkg::rule_t rule_list[$];
	pfrt_pkg::rule_t recent_rules[$];
	logic [63:0] key_pool[$];
	logic    dflt_verdict = 1;
	logic    no_idle = 0;
	logic    taken = 0;
	int      errors = 0;
	int      results_seen = 0;
	int      hits_seen = 0;
	int      status_seen[8];
	int      quiet_cycles = 0;

	packet_filter_rule_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic int find_rule(logic [63:0] key);
		foreach (rule_list[i])
			if (rule_list[i].key == key)
				return i;
		return -1;
	endfunction

	function automatic logic addr_match(logic [31:0] ra, logic [31:0] rm, logic [31:0] pa);
		return ra == 32'd0 || (pa & rm) == (ra & rm);
	endfunction

	// Applies one request to the table copy and returns the answer the block must give.
	function automatic answer_t apply_request(req_t q);
		answer_t a;
		int pos;
		logic bad;
		logic [15:0] sp, dp;
		a = '{pfrt_pkg::ST_OK, 1'b0, 1'b0};
		bad = q.r.sport_lo > q.r.sport_hi || q.r.dport_lo > q.r.dport_hi;
		pos = find_rule(q.r.key);
		case (q.op)
			pfrt_pkg::OP_CLASSIFY: begin
				sp = 16'd0;
				dp = 16'd0;
				if (q.r.proto == pfrt_pkg::PROTO_TCP || q.r.proto == pfrt_pkg::PROTO_UDP) begin
					sp = q.r.sport_lo;
					dp = q.r.dport_lo;
				end
				a.verdict = dflt_verdict;
				foreach (rule_list[i]) begin
					if ((rule_list[i].proto == 8'd0 || rule_list[i].proto == q.r.proto) &&
					    addr_match(rule_list[i].src_addr, rule_list[i].src_mask, q.r.src_addr) &&
					    addr_match(rule_list[i].dst_addr, rule_list[i].dst_mask, q.r.dst_addr) &&
					    rule_list[i].sport_lo <= sp && sp <= rule_list[i].sport_hi &&
					    rule_list[i].dport_lo <= dp && dp <= rule_list[i].dport_hi) begin
						a.verdict = rule_list[i].verdict;
						a.hit = 1'b1;
						break;
					end
				end
			end
			pfrt_pkg::OP_ADD: begin
				if (pos >= 0) a.status = pfrt_pkg::ST_EXISTS;
				else if (bad) a.status = pfrt_pkg::ST_RANGE;
				else if (rule_list.size() >= 64) a.status = pfrt_pkg::ST_FULL;
				else rule_list.push_front(q.r);
			end
			pfrt_pkg::OP_MODIFY: begin
				if (pos < 0) a.status = pfrt_pkg::ST_NOTFOUND;
				else if (bad) a.status = pfrt_pkg::ST_RANGE;
				else rule_list[pos] = q.r;
			end
			default: begin
				if (pos < 0) a.status = pfrt_pkg::ST_NOTFOUND;
				else rule_list.delete(pos);
			end
		endcase
		return a;
	endfunction

	function automatic pfrt_pkg::rule_t random_rule(logic [63:0] key);
		pfrt_pkg::rule_t r;
		int len;
		r.key = key;
		r.src_addr = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
		r.dst_addr = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
		len = $urandom_range(32);
		r.src_mask = ($urandom_range(3) == 0) ? $urandom : (len == 0 ? 32'h0 : ~32'h0 << (32 - len));
		len = $urandom_range(32);
		r.dst_mask = ($urandom_range(3) == 0) ? $urandom : (len == 0 ? 32'h0 : ~32'h0 << (32 - len));
		if ($urandom_range(2) == 0) begin
			r.sport_lo = 16'd0;
			r.sport_hi = 16'hffff;
		end else begin
			r.sport_lo = 16'($urandom_range(65535));
			r.sport_hi = 16'($urandom_range(65535, r.sport_lo));
		end
		if ($urandom_range(2) == 0) begin
			r.dport_lo = 16'd0;
			r.dport_hi = 16'hffff;
		end else begin
			r.dport_lo = 16'($urandom_range(65535));
			r.dport_hi = 16'($urandom_range(65535, r.dport_lo));
		end
		if ($urandom_range(9) == 0) {r.sport_lo, r.sport_hi} = {r.sport_hi + 16'd1, r.sport_hi};
		if ($urandom_range(9) == 0) {r.dport_lo, r.dport_hi} = {r.dport_hi + 16'd1, r.dport_hi};
		case ($urandom_range(3))
			0: r.proto = 8'd0;
			1: r.proto = pfrt_pkg::PROTO_TCP;
			2: r.proto = pfrt_pkg::PROTO_UDP;
			default: r.proto = 8'($urandom);
		endcase
		r.verdict = 1'($urandom);
		return r;
	endfunction

	// Packets are mostly aimed at a rule from a recent add, modify or delete so that matches are common.
	function automatic pfrt_pkg::rule_t random_packet();
		pfrt_pkg::rule_t p, t;
		p = random_rule({$urandom, $urandom});
		if (recent_rules.size() == 0 || $urandom_range(3) == 0)
			return p;
		t = recent_rules[$urandom_range(recent_rules.size() - 1)];
		p.src_addr = (t.src_addr & t.src_mask) | ($urandom & ~t.src_mask);
		p.dst_addr = (t.dst_addr & t.dst_mask) | ($urandom & ~t.dst_mask);
		if (t.proto != 8'd0) p.proto = t.proto;
		if (t.sport_lo <= t.sport_hi) p.sport_lo = 16'($urandom_range(t.sport_hi, t.sport_lo));
		if (t.dport_lo <= t.dport_hi) p.dport_lo = 16'($urandom_range(t.dport_hi, t.dport_lo));
		return p;
	endfunction

	task automatic queue_req(pfrt_pkg::op_e op, pfrt_pkg::rule_t r);
		req_t q;
		q.op = op;
		q.r = r;
		pending.push_back(q);
		if (op != pfrt_pkg::OP_CLASSIFY) begin
			recent_rules.push_back(r);
			if (recent_rules.size() > 64) void'(recent_rules.pop_front());
		end
	endtask

	task automatic fill_random(int count, int add_pct, int del_pct);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < add_pct)
				queue_req(pfrt_pkg::OP_ADD,
					random_rule(key_pool[$urandom_range(key_pool.size() - 1)]));
			else if (pick < add_pct + del_pct)
				queue_req(pfrt_pkg::OP_DELETE,
					random_rule(key_pool[$urandom_range(key_pool.size() - 1)]));
			else if (pick < add_pct + del_pct + 10)
				queue_req(pfrt_pkg::OP_MODIFY, random_rule(($urandom_range(7) == 0) ?
					{$urandom, $urandom} : key_pool[$urandom_range(key_pool.size() - 1)]));
			else
				queue_req(pfrt_pkg::OP_CLASSIFY, random_packet());
		end
	endtask

	task automatic drain_and_settle();
		wait (pending.size() == 0 && answers_due.size() == 0);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_default(logic v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		dflt_verdict = v;
	endtask

	task automatic report(string what, logic [2:0] got, logic [2:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Driver.
	always @(posedge clk)
		if (s_tvalid && s_tready)
			taken = 1;

	always @(negedge clk) begin
		req_t q;
		if (!s_tvalid || taken) begin
			taken = 0;
			if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
				q = pending.pop_front();
				answers_due.push_back(apply_request(q));
				s_tuser <= q.op;
				s_tdata <= {7'd0, q.r.verdict, q.r.proto, q.r.dport_hi, q.r.dport_lo,
				            q.r.sport_hi, q.r.sport_lo, q.r.dst_mask, q.r.dst_addr,
				            q.r.src_mask, q.r.src_addr, q.r.key};
				s_tvalid <= 1;
			end else begin
				s_tvalid <= 0;
			end
		end
		m_tready <= no_idle || $urandom_range(99) >= 34;
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		answer_t a;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (answers_due.size() == 0) begin
				report("unexpected result", m_tdata[2:0], 3'd0);
			end else begin
				a = answers_due.pop_front();
				if (m_tdata[2:0] != a.status) report("status", m_tdata[2:0], a.status);
				if (m_tdata[3] != a.verdict)
					report("verdict", {2'b00, m_tdata[3]}, {2'b00, a.verdict});
				if (m_tdata[4] != a.hit)
					report("rule_hit", {2'b00, m_tdata[4]}, {2'b00, a.hit});
				status_seen[a.status]++;
				hits_seen += int'(a.hit);
			end
		end
	end

	initial begin
		pfrt_pkg::rule_t r, p;
		for (int i = 0; i < 90; i++) key_pool.push_back({$urandom, $urandom});
		key_pool.push_back(64'h0);
		key_pool.push_back(~64'h0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed part.
		r = '{key: ~64'h0, src_addr: ~32'h0, src_mask: ~32'h0, dst_addr: ~32'h0,
		      dst_mask: ~32'h0, sport_lo: 16'hffff, sport_hi: 16'hffff, dport_lo: 16'hffff,
		      dport_hi: 16'hffff, proto: 8'hff, verdict: 1'b0};
		queue_req(pfrt_pkg::OP_CLASSIFY, r);
		queue_req(pfrt_pkg::OP_ADD, r);
		queue_req(pfrt_pkg::OP_CLASSIFY, r);
		queue_req(pfrt_pkg::OP_ADD, r);
		p = r;
		p.key = 64'h0;
		p.sport_lo = 16'hffff;
		p.sport_hi = 16'h0;
		queue_req(pfrt_pkg::OP_ADD, p);
		p.sport_hi = 16'hffff;
		p.dport_hi = 16'h0;
		queue_req(pfrt_pkg::OP_ADD, p);
		queue_req(pfrt_pkg::OP_MODIFY, p);
		p.key = ~64'h0;
		queue_req(pfrt_pkg::OP_MODIFY, p);
		p = '{key: 64'h0, src_addr: 32'h0, src_mask: 32'h0, dst_addr: 32'h0, dst_mask: 32'h0,
		      sport_lo: 16'h0, sport_hi: 16'h0, dport_lo: 16'h0, dport_hi: 16'h0, proto: 8'h0,
		      verdict: 1'b1};
		queue_req(pfrt_pkg::OP_DELETE, p);
		queue_req(pfrt_pkg::OP_ADD, p);
		queue_req(pfrt_pkg::OP_CLASSIFY, p);
		p.proto = 8'd1;
		p.sport_lo = 16'd80;
		p.dport_lo = 16'd443;
		queue_req(pfrt_pkg::OP_CLASSIFY, p);
		p.proto = pfrt_pkg::PROTO_TCP;
		queue_req(pfrt_pkg::OP_CLASSIFY, p);
		p.proto = pfrt_pkg::PROTO_UDP;
		queue_req(pfrt_pkg::OP_CLASSIFY, p);
		r.dport_lo = 16'd0;
		r.sport_lo = 16'd0;
		r.proto = pfrt_pkg::PROTO_TCP;
		queue_req(pfrt_pkg::OP_MODIFY, r);
		queue_req(pfrt_pkg::OP_CLASSIFY, r);
		queue_req(pfrt_pkg::OP_DELETE, p);
		queue_req(pfrt_pkg::OP_DELETE, r);
		queue_req(pfrt_pkg::OP_DELETE, r);
		queue_req(pfrt_pkg::OP_CLASSIFY, r);
		drain_and_settle();

		write_default(0);
		fill_random(140, 30, 15);
		drain_and_settle();
		no_idle = 1;
		fill_random(160, 80, 5);
		drain_and_settle();
		no_idle = 0;
		write_default(1);
		fill_random(140, 20, 10);
		drain_and_settle();
		write_default(0);
		fill_random(120, 10, 50);
		drain_and_settle();
		write_default(1);
		fill_random(140, 30, 20);
		drain_and_settle();

		$display("Ran %0d transfers under both default verdicts; %0d classify hits.",
		         results_seen, hits_seen);
		$display("Status counts ok/exists/range/notfound/full: %0d/%0d/%0d/%0d/%0d.",
		         status_seen[pfrt_pkg::ST_OK], status_seen[pfrt_pkg::ST_EXISTS],
		         status_seen[pfrt_pkg::ST_RANGE], status_seen[pfrt_pkg::ST_NOTFOUND],
		         status_seen[pfrt_pkg::ST_FULL]);
		if (errors == 0 && answers_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
